// ===== src/keyword_token_counter_top_macros.svh =====
// ----------------------------------------------------------------------------
// keyword_token_counter_top_macros - assertion helpers
// Clocked assertion wrappers used by the keyword counter modules (kwc_count).
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TOKEN_COUNTER_TOP_MACROS_SVH
`define KEYWORD_TOKEN_COUNTER_TOP_MACROS_SVH

// Check on every rising edge outside reset.
`define KWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define KWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kwc_pkg.sv =====
// ----------------------------------------------------------------------------
// kwc_pkg - keyword token counter package
// Dictionary tables, widths and the item record passed along the cell row.
// ----------------------------------------------------------------------------
package kwc_pkg;

  localparam int TABLE_WORDS = 4;
  localparam int TABLE_CHARS = 16;
  localparam int POS_BITS    = 5;
  localparam int IDX_BITS    = $clog2(TABLE_CHARS);

  localparam int DEF_DICT_WORDS   = 4;
  localparam int DEF_MAX_WORD_LEN = 16;
  localparam int DEF_COUNT_BITS   = 16;

  localparam int MATCH_BITS = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Lower-case dictionary text, zero padded
  localparam logic [7:0] DICT_TEXT [TABLE_WORDS][TABLE_CHARS] = '{
    '{8'h63, 8'h75, 8'h72, 8'h73, 8'h65, 8'h31, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h63, 8'h75, 8'h72, 8'h73, 8'h65, 8'h32, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h61, 8'h63, 8'h69, 8'h73, 8'h74, 8'h5f, 8'h70,
      8'h68, 8'h72, 8'h61, 8'h73, 8'h65, 8'h31, 8'h00, 8'h00},
    '{8'h72, 8'h61, 8'h63, 8'h69, 8'h73, 8'h74, 8'h5f, 8'h70,
      8'h68, 8'h72, 8'h61, 8'h73, 8'h65, 8'h32, 8'h00, 8'h00}
  };

  localparam logic [POS_BITS-1:0] DICT_LEN [TABLE_WORDS] = '{
    5'd6, 5'd6, 5'd14, 5'd14
  };

  // One byte item after token tracking
  typedef struct packed {
    logic                last;
    logic                do_char;
    logic [7:0]          ch;
    logic [POS_BITS-1:0] char_pos;
    logic                do_close;
    logic                tok;
    logic [POS_BITS-1:0] close_pos;
  } kwc_pkt_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== src/keyword_token_counter_top.sv =====
// ----------------------------------------------------------------------------
// keyword_token_counter_top - keyword token counter
// Counts whole-word, case-insensitive dictionary matches in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one text byte per transfer in in_tdata, in_tlast on
//   the final byte of a string. Spaces split tokens; a zero byte ends the
//   string and later bytes up to in_tlast are dropped.
//   Output channel (out_*): one transfer per string, sent for the in_tlast
//   byte: the match count in out_tdata and the saturation flag in out_tuser.
//   Throughput: one byte per cycle while the cell row is not held by a stall.
//   Pipeline: the last byte is loaded into the token tracker register, then
//   passes one stage per dictionary cell, at most four, then the result
//   register, where the result is presented.
//   Stall: the result register holds until out_tready; bytes keep flowing
//   until a second last byte reaches the tail while a result still waits,
//   then the whole row and in_tready hold.
//   Reset: synchronous, active low; clears the token tracker, stage valids,
//   count and result valid and sets every live flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
module keyword_token_counter_top #(
  parameter int DICT_WORDS   = kwc_pkg::DEF_DICT_WORDS,
  parameter int MAX_WORD_LEN = kwc_pkg::DEF_MAX_WORD_LEN,
  parameter int COUNT_BITS   = kwc_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] ch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] match_count
  output logic        out_tuser    // [0] saturated
);

  // Only the words present in the table take part
  localparam int NCELL = (DICT_WORDS < kwc_pkg::TABLE_WORDS) ? DICT_WORDS
                                                             : kwc_pkg::TABLE_WORDS;

  logic              adv;
  logic              stg_valid [NCELL+1];
  kwc_pkg::kwc_pkt_t stg_pkt   [NCELL+1];
  logic              stg_hit   [NCELL+1];

  // Track tokens and tag each byte with its position
  kwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_take   (in_tvalid && adv),
    .in_ch     (in_tdata),
    .in_last   (in_tlast),
    .out_valid (stg_valid[0]),
    .out_pkt   (stg_pkt[0])
  );

  // No word has matched before the first cell
  assign stg_hit[0] = 1'b0;

  // Advance each item through one cell per dictionary word
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    kwc_cell #(
      .WORD         (g),
      .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stg_valid[g]),
      .in_pkt    (stg_pkt[g]),
      .in_hit    (stg_hit[g]),
      .out_valid (stg_valid[g+1]),
      .out_pkt   (stg_pkt[g+1]),
      .out_hit   (stg_hit[g+1])
    );
  end

  // Count hits, emit the result on the last byte
  kwc_count #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[NCELL]),
    .in_last    (stg_pkt[NCELL].last),
    .in_hit     (stg_hit[NCELL]),
    .ready      (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = adv;

endmodule

// ===== src/kwc_front.sv =====
// ----------------------------------------------------------------------------
// kwc_front - token tracker
// Splits the byte stream into tokens and tags each byte with its position.
// ----------------------------------------------------------------------------
module kwc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_take,
  input  logic [7:0]        in_ch,
  input  logic              in_last,
  output logic              out_valid,
  output kwc_pkg::kwc_pkt_t out_pkt
);

  logic [kwc_pkg::POS_BITS-1:0] pos_r, pos_nxt, pos_inc;
  logic                         tok_r, tok_nxt;
  logic                         ended_r, ended_nxt;
  logic                         valid_r;
  kwc_pkg::kwc_pkt_t            pkt_r, pkt_nxt;
  logic                         is_nul, is_sp, byte_close, byte_char;

  always_comb begin
    is_nul     = (in_ch == kwc_pkg::CH_NUL);
    is_sp      = (in_ch == kwc_pkg::CH_SPACE);
    byte_close = !ended_r && (is_nul || is_sp);
    byte_char  = !ended_r && !is_nul && !is_sp;
    pos_inc    = (pos_r == kwc_pkg::POS_MAX) ? pos_r : pos_r + 1'b1;

    pkt_nxt.last     = in_last;
    pkt_nxt.do_char  = byte_char;
    pkt_nxt.ch       = kwc_pkg::fold_byte(in_ch);
    pkt_nxt.char_pos = pos_r;
    pkt_nxt.do_close = byte_close || in_last;
    pkt_nxt.tok      = byte_char ? 1'b1 : tok_r;
    pkt_nxt.close_pos = byte_char ? pos_inc : pos_r;

    pos_nxt   = pos_r;
    tok_nxt   = tok_r;
    ended_nxt = ended_r;
    priority if (in_last) begin
      pos_nxt   = '0;
      tok_nxt   = 1'b0;
      ended_nxt = 1'b0;
    end else if (byte_close) begin
      pos_nxt   = '0;
      tok_nxt   = 1'b0;
      ended_nxt = is_nul;
    end else if (byte_char) begin
      pos_nxt = pos_inc;
      tok_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      tok_r   <= 1'b0;
      ended_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_take;
      if (in_take) begin
        pos_r   <= pos_nxt;
        tok_r   <= tok_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;

endmodule

// ===== src/kwc_cell.sv =====
// ----------------------------------------------------------------------------
// kwc_cell - one dictionary word
// Holds the live flag of one word and folds its hit into the passing item.
// ----------------------------------------------------------------------------
module kwc_cell #(
  parameter int WORD         = 0,
  parameter int MAX_WORD_LEN = kwc_pkg::DEF_MAX_WORD_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  kwc_pkg::kwc_pkt_t in_pkt,
  input  logic              in_hit,
  output logic              out_valid,
  output kwc_pkg::kwc_pkt_t out_pkt,
  output logic              out_hit
);

  localparam logic [kwc_pkg::POS_BITS-1:0] LEN = kwc_pkg::DICT_LEN[WORD];
  localparam bit LEN_OK = (int'(LEN) > 0) && (int'(LEN) <= MAX_WORD_LEN);
  localparam logic [kwc_pkg::POS_BITS-1:0] CHARS =
    kwc_pkg::POS_BITS'(kwc_pkg::TABLE_CHARS - 1);

  logic              alive_r, alive_nxt, alive_mid, chr_ok, hit_nxt;
  logic              valid_r;
  kwc_pkg::kwc_pkt_t pkt_r;
  logic              hit_r;

  always_comb begin
    chr_ok = (in_pkt.char_pos < LEN) && (in_pkt.char_pos <= CHARS) &&
             (kwc_pkg::DICT_TEXT[WORD][in_pkt.char_pos[kwc_pkg::IDX_BITS-1:0]] == in_pkt.ch);
    // apply the byte first, then the close
    alive_mid = in_pkt.do_char ? (alive_r && chr_ok) : alive_r;
    hit_nxt   = in_hit || (in_pkt.do_close && in_pkt.tok && alive_mid && LEN_OK &&
                           (in_pkt.close_pos == LEN));
    alive_nxt = in_pkt.do_close ? 1'b1 : alive_mid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= 1'b1;
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
      if (in_valid) begin
        alive_r <= alive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pkt_r <= in_pkt;
      hit_r <= hit_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pkt   = pkt_r;
  assign out_hit   = hit_r;

endmodule

// ===== src/kwc_count.sv =====
// ----------------------------------------------------------------------------
// kwc_count - match counter and result register
// Counts hits with saturation and presents the count on the last item.
// ----------------------------------------------------------------------------
`include "keyword_token_counter_top_macros.svh"

module kwc_count #(
  parameter int COUNT_BITS = kwc_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_last,
  input  logic                           in_hit,
  output logic                           ready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [kwc_pkg::MATCH_BITS-1:0] out_tdata,
  output logic                           out_tuser
);

  localparam int EXT_BITS = (COUNT_BITS > kwc_pkg::MATCH_BITS) ? COUNT_BITS
                                                               : kwc_pkg::MATCH_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0]         cnt_r, cnt_new;
  logic                          sat_r, sat_new;
  logic                          out_tvalid_r;
  logic [kwc_pkg::MATCH_BITS-1:0] out_data_r;
  logic                          out_sat_r;
  logic [EXT_BITS-1:0]           cnt_ext;
  logic                          take;

  always_comb begin
    cnt_new = (in_hit && cnt_r != CMAX) ? cnt_r + 1'b1 : cnt_r;
    sat_new = (cnt_new == CMAX);
    cnt_ext = EXT_BITS'(cnt_new);
    // hold the tail only when a result would overwrite one still waiting
    ready   = !(in_valid && in_last && out_tvalid_r && !out_tready);
    take    = in_valid && ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      sat_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (take) begin
        if (in_last) begin
          cnt_r        <= '0;
          sat_r        <= 1'b0;
          out_tvalid_r <= 1'b1;
        end else begin
          cnt_r <= cnt_new;
          sat_r <= sat_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last) begin
      out_data_r <= cnt_ext[kwc_pkg::MATCH_BITS-1:0];
      out_sat_r  <= sat_new;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  `KWC_ASSERT(a_sat_at_max, sat_r |-> (cnt_r == CMAX), "saturated flag without full count")
  `KWC_ASSERT(a_stall_only_full, !ready |-> out_tvalid_r, "tail held with empty result register")
  `KWC_ASSERT(a_last_clears, (take && in_last) |=> (cnt_r == '0 && !sat_r && out_tvalid_r),
              "count not restarted after result")

endmodule
